>>> design/hashed_pair_count_table_assert.svh
// ----------------------------------------------------------------------------
// hashed_pair_count_table_assert
// Assertion macros for hashed_pair_count_table, which checks its own logic.
// ----------------------------------------------------------------------------
`ifndef HASHED_PAIR_COUNT_TABLE_ASSERT_SVH
`define HASHED_PAIR_COUNT_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hpct assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HPCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hpct assertion failed");

`endif

>>> design/hpct_pkg.sv
// ----------------------------------------------------------------------------
// hpct_pkg
// Types and constants of the hashed pair count table.
// ----------------------------------------------------------------------------
`default_nettype none

package hpct_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;
	localparam int LIMIT_W = 10;
	localparam int ENTRY_W = 11;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd716;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	localparam logic [1:0] OP_INC = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_SUM = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [63:0] key;
		logic [31:0] delta;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [31:0] count;
		logic [63:0] checksum;
		logic [ENTRY_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic used;
		logic [63:0] key;
		logic [31:0] count;
	} slot_t;

	typedef struct packed {
		logic init;
		logic pop;
	} bk_ctl_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_HASH,
		B_READ,
		B_CHECK,
		B_SEED,
		B_SCAN_RD,
		B_SCAN_CHK,
		B_SCAN_MIX,
		B_FIN_GO,
		B_FIN
	} bk_state_t;

endpackage

`default_nettype wire

>>> design/hashed_pair_count_table.sv
// ----------------------------------------------------------------------------
// hashed_pair_count_table
// Counting hash table of 64-bit keys with 32-bit counts, linear probing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; it carries op, key
// and delta. Requests wait in a two-entry queue, so busy rises only when the
// queue is full or the table is being swept after reset.
// Each result appears on rsp for exactly one cycle with done high; the
// receiver cannot hold it off, and results come back in request order.
// The back end serves one request at a time. Increment and lookup first
// pass through dispatch and hashing (one shared 32x32 multiplier), then
// read and check one slot of the single-port slot memory per probe, and
// done follows the check that ends the probing.
// Checksum walks all 1024 slots, reading each one and passing each used slot
// through the mixer, plus two mixer passes for the seed and the result.
// Clear sweeps all 1024 slots of the memory, then raises done.
// After reset the block clears all 1024 slots with busy high.
// cfg_we writes entry_limit; the user must write it only while no request is in flight (not enforced); reset value 716.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_pair_count_table_assert.svh"

module hashed_pair_count_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire hpct_pkg::req_t req,
	output logic done,
	output hpct_pkg::rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [hpct_pkg::LIMIT_W-1:0] cfg_wdata
);

	logic [hpct_pkg::LIMIT_W-1:0] limit_q;
	logic empty;
	hpct_pkg::req_t head;
	hpct_pkg::bk_ctl_t bk_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= hpct_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	hpct_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.bk_ctl(bk_ctl),
		.empty(empty),
		.head(head)
	);

	hpct_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry_limit(limit_q),
		.empty(empty),
		.head(head),
		.bk_ctl(bk_ctl),
		.done(done),
		.rsp(rsp)
	);

	`HPCT_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`HPCT_ASSERT_NOW(a_entries_bounded, clk, arst_n, done,
		rsp.entry_count <= hpct_pkg::ENTRY_W'(hpct_pkg::CAPACITY))
	`HPCT_ASSERT_NOW(a_limit_empty, clk, arst_n, done && rsp.status == hpct_pkg::ST_LIMIT,
		!rsp.found && rsp.count == 32'd0)

endmodule

`default_nettype wire

>>> design/hpct_front.sv
// ----------------------------------------------------------------------------
// hpct_front
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hpct_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire hpct_pkg::req_t req,
	input wire hpct_pkg::bk_ctl_t bk_ctl,
	output logic empty,
	output hpct_pkg::req_t head
);

	hpct_pkg::req_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;
	logic push;

	assign busy = (fill_q == 2'd2) || bk_ctl.init;
	assign push = start && !busy;
	assign empty = (fill_q == 2'd0);
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (bk_ctl.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, bk_ctl.pop};
		end
	end

endmodule

`default_nettype wire

>>> design/hpct_mixer.sv
// ----------------------------------------------------------------------------
// hpct_mixer
// Iterative 64-bit mixer built around one 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hpct_mixer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] din,
	output logic done,
	output logic [63:0] dout
);

	logic [2:0] step_q;
	logic [63:0] v_q;
	logic [63:0] acc_q;
	logic [63:0] c_sel;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] acc_next;

	always_comb begin
		c_sel = (step_q >= 3'd4) ? hpct_pkg::MIX_C2 : hpct_pkg::MIX_C1;
		mul_a = v_q[31:0];
		mul_b = c_sel[31:0];
		case (step_q)
			3'd2, 3'd5: mul_a = v_q[63:32];
			3'd3, 3'd6: mul_b = c_sel[63:32];
			default: ;
		endcase
		prod = {32'd0, mul_a} * {32'd0, mul_b};
		case (step_q)
			3'd1, 3'd4: acc_next = prod;
			default: acc_next = acc_q + {prod[31:0], 32'd0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= din ^ (din >> 30);
		end else if (step_q == 3'd3) begin
			v_q <= acc_next ^ (acc_next >> 27);
		end
		acc_q <= acc_next;
		if (step_q == 3'd6) begin
			dout <= acc_next ^ (acc_next >> 31);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
			done <= 1'b0;
		end else begin
			done <= (step_q == 3'd6);
			if (start) begin
				step_q <= 3'd1;
			end else if (step_q == 3'd6) begin
				step_q <= 3'd0;
			end else if (step_q != 3'd0) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/hpct_back.sv
// ----------------------------------------------------------------------------
// hpct_back
// Table engine: probing, update, checksum walk and clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module hpct_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [hpct_pkg::LIMIT_W-1:0] entry_limit,
	input wire logic empty,
	input wire hpct_pkg::req_t head,
	output hpct_pkg::bk_ctl_t bk_ctl,
	output logic done,
	output hpct_pkg::rsp_t rsp
);

	localparam int IW = hpct_pkg::IDX_W;
	localparam int CW = hpct_pkg::CNT_W;

	hpct_pkg::slot_t mem [hpct_pkg::CAPACITY];
	hpct_pkg::slot_t rd_q;
	hpct_pkg::bk_state_t state_q;
	hpct_pkg::bk_state_t state_d;
	hpct_pkg::req_t req_q;
	hpct_pkg::rsp_t rsp_d;
	logic [IW-1:0] pos_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] probes_q;
	logic [CW-1:0] stored_q;
	logic [63:0] sum_q;
	logic [63:0] xor_q;
	logic clr_rsp_q;
	logic mem_re;
	logic mem_we;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	hpct_pkg::slot_t wr_data;
	logic mix_start;
	logic [63:0] mix_in;
	logic mix_done;
	logic [63:0] mix_out;
	logic rsp_fire;
	logic hit;
	logic free;
	logic last_probe;
	logic last_idx;
	logic at_limit;
	logic is_inc;
	logic [32:0] add;

	hpct_mixer u_mixer (
		.clk(clk),
		.arst_n(arst_n),
		.start(mix_start),
		.din(mix_in),
		.done(mix_done),
		.dout(mix_out)
	);

	assign hit = rd_q.used && (rd_q.key == req_q.key);
	assign free = !rd_q.used;
	assign last_probe = (probes_q == CW'(hpct_pkg::CAPACITY - 1));
	assign last_idx = &idx_q;
	assign at_limit = (stored_q >= CW'(entry_limit));
	assign is_inc = (req_q.op == hpct_pkg::OP_INC);
	assign add = {1'b0, rd_q.count} + {1'b0, req_q.delta};

	always_comb begin
		state_d = state_q;
		case (state_q)
			hpct_pkg::B_CLEAR: if (last_idx) state_d = hpct_pkg::B_IDLE;
			hpct_pkg::B_IDLE: begin
				if (!empty) begin
					if (head.op inside {hpct_pkg::OP_INC, hpct_pkg::OP_LOOKUP}) begin
						state_d = hpct_pkg::B_HASH;
					end else if (head.op == hpct_pkg::OP_SUM) begin
						state_d = hpct_pkg::B_SEED;
					end else begin
						state_d = hpct_pkg::B_CLEAR;
					end
				end
			end
			hpct_pkg::B_HASH: if (mix_done) state_d = hpct_pkg::B_READ;
			hpct_pkg::B_READ: state_d = hpct_pkg::B_CHECK;
			hpct_pkg::B_CHECK: begin
				state_d = (free || hit || last_probe) ? hpct_pkg::B_IDLE : hpct_pkg::B_READ;
			end
			hpct_pkg::B_SEED: if (mix_done) state_d = hpct_pkg::B_SCAN_RD;
			hpct_pkg::B_SCAN_RD: state_d = hpct_pkg::B_SCAN_CHK;
			hpct_pkg::B_SCAN_CHK: begin
				if (rd_q.used) begin
					state_d = hpct_pkg::B_SCAN_MIX;
				end else begin
					state_d = last_idx ? hpct_pkg::B_FIN_GO : hpct_pkg::B_SCAN_RD;
				end
			end
			hpct_pkg::B_SCAN_MIX: begin
				if (mix_done) begin
					state_d = last_idx ? hpct_pkg::B_FIN_GO : hpct_pkg::B_SCAN_RD;
				end
			end
			hpct_pkg::B_FIN_GO: state_d = hpct_pkg::B_FIN;
			hpct_pkg::B_FIN: if (mix_done) state_d = hpct_pkg::B_IDLE;
			default: state_d = hpct_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		bk_ctl.init = (state_q == hpct_pkg::B_CLEAR) && !clr_rsp_q;
		bk_ctl.pop = 1'b0;
		mem_re = 1'b0;
		mem_we = 1'b0;
		rd_addr = pos_q;
		wr_addr = pos_q;
		wr_data = {1'b1, req_q.key, req_q.delta};
		mix_start = 1'b0;
		mix_in = head.key;
		rsp_fire = 1'b0;
		rsp_d = '0;
		rsp_d.entry_count = hpct_pkg::ENTRY_W'(stored_q);
		case (state_q)
			hpct_pkg::B_CLEAR: begin
				mem_we = 1'b1;
				wr_addr = idx_q;
				wr_data = '0;
				rsp_fire = last_idx && clr_rsp_q;
				rsp_d.entry_count = '0;
			end
			hpct_pkg::B_IDLE: begin
				bk_ctl.pop = !empty;
				mix_start = !empty && (head.op != hpct_pkg::OP_CLEAR);
				if (head.op == hpct_pkg::OP_SUM) begin
					mix_in = 64'(stored_q);
				end
			end
			hpct_pkg::B_READ: mem_re = 1'b1;
			hpct_pkg::B_CHECK: begin
				if (hit) begin
					rsp_fire = 1'b1;
					rsp_d.found = 1'b1;
					rsp_d.count = rd_q.count;
					if (is_inc) begin
						if (add[32]) begin
							rsp_d.status = hpct_pkg::ST_OVERFLOW;
						end else begin
							mem_we = 1'b1;
							wr_data = {1'b1, req_q.key, add[31:0]};
							rsp_d.count = add[31:0];
						end
					end
				end else if (free || last_probe) begin
					rsp_fire = 1'b1;
					if (!is_inc) begin
						rsp_d.status = hpct_pkg::ST_ABSENT;
					end else if (!free || at_limit) begin
						rsp_d.status = hpct_pkg::ST_LIMIT;
					end else begin
						mem_we = 1'b1;
						rsp_d.count = req_q.delta;
						rsp_d.entry_count = hpct_pkg::ENTRY_W'(stored_q + CW'(1));
					end
				end
			end
			hpct_pkg::B_SCAN_RD: begin
				mem_re = 1'b1;
				rd_addr = idx_q;
			end
			hpct_pkg::B_SCAN_CHK: begin
				mix_start = rd_q.used;
				mix_in = rd_q.key ^ {31'd0, rd_q.count, 1'b0};
			end
			hpct_pkg::B_FIN_GO: begin
				mix_start = 1'b1;
				mix_in = sum_q;
			end
			hpct_pkg::B_FIN: begin
				rsp_fire = mix_done;
				rsp_d.checksum = mix_out ^ xor_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
		if (rsp_fire) begin
			rsp <= rsp_d;
		end
		if (bk_ctl.pop) begin
			req_q <= head;
		end
		if (state_q == hpct_pkg::B_HASH) begin
			pos_q <= mix_out[IW-1:0];
			probes_q <= '0;
		end else if (state_q == hpct_pkg::B_CHECK) begin
			pos_q <= pos_q + IW'(1);
			probes_q <= probes_q + CW'(1);
		end
		if (state_q == hpct_pkg::B_SEED) begin
			sum_q <= mix_out;
			xor_q <= '0;
		end else if (state_q == hpct_pkg::B_SCAN_MIX && mix_done) begin
			sum_q <= sum_q + mix_out;
			xor_q <= xor_q ^ mix_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hpct_pkg::B_CLEAR;
			idx_q <= '0;
			stored_q <= '0;
			clr_rsp_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= rsp_fire;
			case (state_q)
				hpct_pkg::B_CLEAR: idx_q <= idx_q + IW'(1);
				hpct_pkg::B_IDLE: begin
					idx_q <= '0;
					if (!empty && head.op == hpct_pkg::OP_CLEAR) begin
						stored_q <= '0;
						clr_rsp_q <= 1'b1;
					end
				end
				hpct_pkg::B_CHECK: begin
					if (is_inc && free && !hit && !at_limit) begin
						stored_q <= stored_q + CW'(1);
					end
				end
				hpct_pkg::B_SCAN_CHK: begin
					if (!rd_q.used && !last_idx) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				hpct_pkg::B_SCAN_MIX: begin
					if (mix_done && !last_idx) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hashed pair count table. A queue of planned
// requests and register writes feeds a clocked driver that sends requests in
// random bursts. Every accepted request is run through a local copy of the
// table, and the monitor checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import hpct_pkg::*;

	typedef struct {
		bit is_cfg;
		logic [LIMIT_W-1:0] limit;
		req_t r;
	} plan_t;

	localparam int WATCHDOG = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	hashed_pair_count_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	plan_t plan_q[$];
	rsp_t want_rsp[$];
	logic [63:0] key_pool[$];

	bit m_used[CAPACITY];
	logic [63:0] m_key[CAPACITY];
	logic [31:0] m_cnt[CAPACITY];
	logic [ENTRY_W-1:0] m_entries = '0;
	logic [LIMIT_W-1:0] m_limit = LIMIT_RESET;

	int errors = 0;
	int quiet = 0;
	int stalled = 0;
	int burst_left = 8;
	int gap_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] mix64(logic [63:0] v);
		v = v ^ (v >> 30);
		v = v * MIX_C1;
		v = v ^ (v >> 27);
		v = v * MIX_C2;
		v = v ^ (v >> 31);
		return v;
	endfunction

	function automatic rsp_t count_table_apply(req_t r);
		rsp_t o;
		int pos;
		int slot;
		bit hit;
		logic [63:0] sum;
		logic [63:0] x;
		logic [63:0] item;
		o = '0;
		slot = -1;
		hit = 0;
		if (r.op == OP_INC || r.op == OP_LOOKUP) begin
			pos = int'(mix64(r.key) & (CAPACITY - 1));
			for (int n = 0; n < CAPACITY; n++) begin
				if (!m_used[pos]) begin
					slot = pos;
					break;
				end
				if (m_key[pos] == r.key) begin
					slot = pos;
					hit = 1;
					break;
				end
				pos = (pos + 1) & (CAPACITY - 1);
			end
		end
		case (r.op)
			OP_INC: begin
				if (hit) begin
					o.found = 1'b1;
					if (33'(m_cnt[slot]) + 33'(r.delta) > 33'hFFFF_FFFF) begin
						o.status = ST_OVERFLOW;
					end else begin
						m_cnt[slot] = m_cnt[slot] + r.delta;
					end
					o.count = m_cnt[slot];
				end else if (slot < 0 || m_entries >= ENTRY_W'(m_limit)) begin
					o.status = ST_LIMIT;
				end else begin
					m_used[slot] = 1;
					m_key[slot] = r.key;
					m_cnt[slot] = r.delta;
					m_entries = m_entries + 1'b1;
					o.count = r.delta;
				end
			end
			OP_LOOKUP: begin
				if (hit) begin
					o.found = 1'b1;
					o.count = m_cnt[slot];
				end else begin
					o.status = ST_ABSENT;
				end
			end
			OP_SUM: begin
				sum = mix64(64'(m_entries));
				x = '0;
				for (int i = 0; i < CAPACITY; i++) begin
					if (m_used[i]) begin
						item = mix64(m_key[i] ^ {31'd0, m_cnt[i], 1'b0});
						sum = sum + item;
						x = x ^ item;
					end
				end
				o.checksum = mix64(sum) ^ x;
			end
			default: begin
				for (int i = 0; i < CAPACITY; i++) m_used[i] = 0;
				m_entries = '0;
			end
		endcase
		o.entry_count = m_entries;
		return o;
	endfunction

	task automatic add_req(logic [1:0] op, logic [63:0] key, logic [31:0] delta);
		plan_t p;
		p.is_cfg = 0;
		p.limit = '0;
		p.r.op = op;
		p.r.key = key;
		p.r.delta = delta;
		plan_q.push_back(p);
		if (op == OP_INC) key_pool.push_back(key);
	endtask

	task automatic add_cfg(logic [LIMIT_W-1:0] lim);
		plan_t p;
		p.is_cfg = 1;
		p.limit = lim;
		p.r = '0;
		plan_q.push_back(p);
	endtask

	function automatic logic [63:0] pick_key(int fresh_pct);
		if (key_pool.size() == 0 || $urandom_range(99) < fresh_pct)
			return {$urandom, $urandom};
		return key_pool[$urandom_range(key_pool.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(9))
			0: return '0;
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return $urandom;
			default: return $urandom_range(1000);
		endcase
	endfunction

	initial begin
		logic [LIMIT_W-1:0] phase_limit[6];
		int fresh;
		int w;
		phase_limit = '{10'd1023, 10'd1, 10'd50, 10'd0, 10'd716, 10'd300};

		add_req(OP_INC, 64'd0, 32'd0);
		add_req(OP_INC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		add_req(OP_INC, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
		add_req(OP_INC, 64'd0, 32'hFFFF_FFFF);
		add_req(OP_INC, 64'd0, 32'd0);
		add_req(OP_LOOKUP, 64'd0, 32'd0);
		add_req(OP_LOOKUP, 64'h1234_5678_9ABC_DEF0, 32'hFFFF_FFFF);
		add_req(OP_SUM, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		add_req(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		add_req(OP_LOOKUP, 64'd0, 32'd0);
		add_req(OP_SUM, 64'd0, 32'd0);
		add_cfg(10'd0);
		add_req(OP_INC, 64'h5555_AAAA_5555_AAAA, 32'd7);
		add_cfg(10'd2);
		add_req(OP_INC, 64'd11, 32'd1);
		add_req(OP_INC, 64'd12, 32'd2);
		add_req(OP_INC, 64'd13, 32'd3);
		add_req(OP_INC, 64'd11, 32'd5);
		add_req(OP_SUM, 64'd0, 32'd0);
		add_req(OP_CLEAR, 64'd0, 32'd0);

		for (int ph = 0; ph < 6; ph++) begin
			add_cfg(ph == 5 ? 10'($urandom_range(1, 1023)) : phase_limit[ph]);
			fresh = (ph == 0) ? 75 : 40;
			for (int i = 0; i < 250; i++) begin
				w = $urandom_range(999);
				if (w < 580) add_req(OP_INC, pick_key(fresh), pick_delta());
				else if (w < 970) add_req(OP_LOOKUP, pick_key(30), $urandom);
				else if (w < 990) add_req(OP_SUM, {$urandom, $urandom}, $urandom);
				else add_req(OP_CLEAR, {$urandom, $urandom}, $urandom);
			end
		end
		add_req(OP_SUM, 64'd0, 32'd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (plan_q.size() != 0 || start || want_rsp.size() != 0);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		logic go;
		logic we;
		plan_t p;
		go = start;
		we = 1'b0;
		if (start && !busy) begin
			want_rsp.push_back(count_table_apply(req));
			go = 0;
		end
		if (arst_n && !go) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (plan_q.size() != 0) begin
				p = plan_q[0];
				if (p.is_cfg) begin
					if (want_rsp.size() == 0 && quiet >= 16) begin
						we = 1'b1;
						cfg_wdata <= p.limit;
						m_limit = p.limit;
						void'(plan_q.pop_front());
					end
				end else begin
					go = 1;
					req <= p.r;
					void'(plan_q.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
					end
				end
			end
		end
		cfg_we <= we;
		start <= go;
	end

	always @(posedge clk) begin
		rsp_t e;
		if (done) begin
			quiet <= 0;
			if (want_rsp.size() == 0) begin
				errors++;
				if (errors <= 10) $display("tb: unexpected result %h", rsp);
			end else begin
				e = want_rsp.pop_front();
				if (rsp.status !== e.status || rsp.found !== e.found ||
				    rsp.count !== e.count || rsp.checksum !== e.checksum ||
				    rsp.entry_count !== e.entry_count) begin
					errors++;
					if (errors <= 10)
						$display({"tb: mismatch exp st=%0d f=%0d cnt=%h sum=%h n=%0d",
							" got st=%0d f=%0d cnt=%h sum=%h n=%0d"},
							e.status, e.found, e.count, e.checksum, e.entry_count,
							rsp.status, rsp.found, rsp.count, rsp.checksum,
							rsp.entry_count);
				end
			end
		end else begin
			quiet <= quiet + 1;
		end
		if (done || (start && !busy)) stalled <= 0;
		else stalled <= stalled + 1;
		if (stalled >= WATCHDOG) begin
			$display("tb: FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
